>>> rtl/rdh_pkg.sv
// Package for the route de-duplication table: field widths, action and status
// codes, request and result payload types and parameter defaults.
// No dependencies.
package rdh_pkg;

	localparam int ACTION_W = 2;
	localparam int BIDX_W   = 10;
	localparam int TAG_W    = 10;
	localparam int RLEN_W   = 32;
	localparam int EPS_W    = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 14;

	localparam int TABLE_SIZE_DEF     = 1024;
	localparam int BUCKET_ENTRIES_DEF = 8;
	localparam int LENGTH_BITS_DEF    = 32;

	localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BETTER    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [BIDX_W-1:0]   bucket_index;
		logic [TAG_W-1:0]    tag;
		logic [RLEN_W-1:0]   route_length;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  route_count;
	} result_t;

endpackage

>>> rtl/rdh_bucket_match.sv
// Tag search over one bucket row: finds the first live slot holding the tag
// and returns its slot index and stored length. Depends on rdh_pkg.
module rdh_bucket_match
	import rdh_pkg::*;
#(
	parameter int BUCKET_ENTRIES = BUCKET_ENTRIES_DEF,
	parameter int LENGTH_BITS    = LENGTH_BITS_DEF,
	localparam int EW = TAG_W + LENGTH_BITS,
	localparam int FW = $clog2(BUCKET_ENTRIES + 1),
	localparam int SW = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1
) (
	input  logic [BUCKET_ENTRIES-1:0][EW-1:0] row,
	input  logic [FW-1:0]                     fill,
	input  logic [TAG_W-1:0]                  tag,
	output logic                              hit,
	output logic [SW-1:0]                     hit_idx,
	output logic [LENGTH_BITS-1:0]            hit_len
);

	logic [BUCKET_ENTRIES-1:0] match;
	logic [BUCKET_ENTRIES-1:0] first;

	always_comb begin
		for (int i = 0; i < BUCKET_ENTRIES; i++) begin
			match[i] = (FW'(i) < fill) && (row[i][EW-1 -: TAG_W] == tag);
		end
	end

	assign first = match & (~match + BUCKET_ENTRIES'(1));
	assign hit   = |match;

	always_comb begin
		hit_idx = '0;
		hit_len = '0;
		for (int i = 0; i < BUCKET_ENTRIES; i++) begin
			if (first[i]) begin
				hit_idx = hit_idx | SW'(i);
				hit_len = hit_len | row[i][LENGTH_BITS-1:0];
			end
		end
	end

endmodule

>>> rtl/route_dedup_hash_table.sv
// Route de-duplication table. An add or remove request passes through bucket
// reduction, one read of the fill and entry memories, tag search, then
// write-back and result before the next request is accepted. A clear request
// sweeps the fill memory one bucket a cycle. After reset the same sweep runs
// over every bucket before the first request is taken. A result held by
// result_stall holds write-back of the next request until it is taken. Write
// the epsilon register only while no request is in flight.
module route_dedup_hash_table
	import rdh_pkg::*;
#(
	parameter int TABLE_SIZE     = TABLE_SIZE_DEF,
	parameter int BUCKET_ENTRIES = BUCKET_ENTRIES_DEF,
	parameter int LENGTH_BITS    = LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_wen,
	input  logic [EPS_W-1:0] cfg_wdata
);

	localparam int BW    = $clog2(TABLE_SIZE);
	localparam int EW    = TAG_W + LENGTH_BITS;
	localparam int FW    = $clog2(BUCKET_ENTRIES + 1);
	localparam int SW    = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;
	localparam int DW    = (LENGTH_BITS > EPS_W) ? LENGTH_BITS : EPS_W;
	localparam int MOD_K = BIDX_W + BW;
	localparam longint MOD_M = ((64'd1 << MOD_K) + TABLE_SIZE - 1) / TABLE_SIZE;
	localparam int MOD_MW = $clog2(MOD_M + 1);
	localparam int TSW   = $clog2(TABLE_SIZE + 1);
	localparam int PW1   = BIDX_W + MOD_MW;
	localparam int PW2   = BIDX_W + TSW;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ADDR  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;
	localparam logic [2:0] S_WRITE = 3'd5;

	logic [2:0]                        state_q;
	logic [BW-1:0]                     sweep_q;
	logic [EPS_W-1:0]                  eps_q;
	logic [COUNT_W-1:0]                count_q;
	item_t                             req_q;
	logic [BIDX_W-1:0]                 quot_q;
	logic [BW-1:0]                     bucket_q;
	logic [FW-1:0]                     fill_rd_s1;
	logic [BUCKET_ENTRIES-1:0][EW-1:0] row_s1;
	logic                              hit_s2;
	logic [SW-1:0]                     hit_idx_s2;
	logic [LENGTH_BITS-1:0]            hit_len_s2;
	logic                              result_valid_q;
	result_t                           result_q;

	logic [FW-1:0]                     fill_mem [TABLE_SIZE];
	logic [BUCKET_ENTRIES-1:0][EW-1:0] entry_mem [TABLE_SIZE];

	logic                              accept;
	logic                              go;
	logic                              sweep_last;
	logic [PW1-1:0]                    quot_prod;
	logic [PW2-1:0]                    rem_full;
	logic [BW-1:0]                     bucket_c;
	logic                              hit_c;
	logic [SW-1:0]                     hit_idx_c;
	logic [LENGTH_BITS-1:0]            hit_len_c;
	logic [LENGTH_BITS-1:0]            len_c;
	logic [DW-1:0]                     diff_c;
	logic                              better_c;
	logic                              full_c;
	logic                              is_add;
	logic                              is_remove;
	logic                              is_clear;
	logic [STATUS_W-1:0]               status_c;
	logic [COUNT_W-1:0]                count_c;
	logic                              entry_we;
	logic [BUCKET_ENTRIES-1:0][EW-1:0] row_c;
	logic                              fill_upd;
	logic [FW-1:0]                     fill_new;
	logic                              fill_we;
	logic [BW-1:0]                     fill_waddr;
	logic [FW-1:0]                     fill_wdata;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign go         = !result_valid_q || !result_stall;
	assign sweep_last = (sweep_q == BW'(TABLE_SIZE - 1));

	assign quot_prod = PW1'(item.bucket_index) * PW1'(MOD_M);
	assign rem_full  = PW2'(req_q.bucket_index) - PW2'(quot_q) * PW2'(TABLE_SIZE);
	assign bucket_c  = rem_full[BW-1:0];

	rdh_bucket_match #(
		.BUCKET_ENTRIES (BUCKET_ENTRIES),
		.LENGTH_BITS    (LENGTH_BITS)
	) u_match (
		.row     (row_s1),
		.fill    (fill_rd_s1),
		.tag     (req_q.tag),
		.hit     (hit_c),
		.hit_idx (hit_idx_c),
		.hit_len (hit_len_c)
	);

	assign len_c     = LENGTH_BITS'(req_q.route_length);
	assign diff_c    = DW'(hit_len_s2) - DW'(len_c);
	assign better_c  = hit_s2 && (len_c < hit_len_s2) && (diff_c > DW'(eps_q));
	assign full_c    = (fill_rd_s1 == FW'(BUCKET_ENTRIES));
	assign is_add    = (req_q.action == ACT_ADD);
	assign is_remove = (req_q.action == ACT_REMOVE);
	assign is_clear  = (req_q.action == ACT_CLEAR);

	always_comb begin
		status_c = ST_NOT_FOUND;
		count_c  = count_q;
		entry_we = 1'b0;
		fill_upd = 1'b0;
		fill_new = fill_rd_s1;
		row_c    = row_s1;
		case (req_q.action)
			ACT_ADD: begin
				if (hit_s2) begin
					status_c = better_c ? ST_BETTER : ST_DUPLICATE;
					entry_we = better_c;
					row_c[hit_idx_s2][LENGTH_BITS-1:0] = len_c;
				end else if (full_c) begin
					status_c = ST_FULL;
				end else begin
					status_c = ST_ADDED;
					count_c  = count_q + COUNT_W'(1);
					entry_we = 1'b1;
					fill_upd = 1'b1;
					fill_new = fill_rd_s1 + FW'(1);
					for (int j = 0; j < BUCKET_ENTRIES; j++) begin
						if (FW'(j) == fill_rd_s1) begin
							row_c[j] = {req_q.tag, len_c};
						end
					end
				end
			end
			ACT_REMOVE: begin
				if (hit_s2) begin
					status_c = ST_REMOVED;
					count_c  = count_q - COUNT_W'(1);
					entry_we = 1'b1;
					fill_upd = 1'b1;
					fill_new = fill_rd_s1 - FW'(1);
					for (int j = 0; j < BUCKET_ENTRIES - 1; j++) begin
						if (SW'(j) >= hit_idx_s2) begin
							row_c[j] = row_s1[j + 1];
						end
					end
				end
			end
			ACT_CLEAR: begin
				status_c = ST_CLEARED;
				count_c  = '0;
			end
			default: begin
				status_c = ST_NOT_FOUND;
			end
		endcase
	end

	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = bucket_q;
		fill_wdata = fill_new;
		if (state_q == S_INIT || state_q == S_CLEAR) begin
			fill_we    = 1'b1;
			fill_waddr = sweep_q;
			fill_wdata = '0;
		end else if (state_q == S_WRITE && go && fill_upd) begin
			fill_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (state_q == S_ADDR) begin
			fill_rd_s1 <= fill_mem[bucket_c];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WRITE && go && entry_we) begin
			entry_mem[bucket_q] <= row_c;
		end
		if (state_q == S_ADDR) begin
			row_s1 <= entry_mem[bucket_c];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= item;
			quot_q <= BIDX_W'(quot_prod >> MOD_K);
		end
		if (state_q == S_ADDR) begin
			bucket_q <= bucket_c;
		end
		if (state_q == S_EVAL) begin
			hit_s2     <= hit_c;
			hit_idx_s2 <= hit_idx_c;
			hit_len_s2 <= hit_len_c;
		end
		if (state_q == S_WRITE && go) begin
			result_q.status      <= status_c;
			result_q.route_count <= count_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			sweep_q        <= '0;
			eps_q          <= EPS_RESET;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				eps_q <= cfg_wdata;
			end
			if (state_q == S_WRITE && go) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + BW'(1);
					if (sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					sweep_q <= '0;
					state_q <= is_clear ? S_CLEAR : S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_WRITE;
				end
				S_CLEAR: begin
					sweep_q <= sweep_q + BW'(1);
					if (sweep_last) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (go) begin
						count_q <= count_c;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> fill_wdata <= FW'(BUCKET_ENTRIES))
		else $error("bucket fill written beyond bucket capacity");

	a_entry_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && go && entry_we) |-> (is_add || is_remove))
		else $error("entry row written by a request that does not change it");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && go && is_clear) |=>
		(result_q.status == ST_CLEARED && result_q.route_count == '0 && count_q == '0))
		else $error("clear request did not report an empty table");

	a_no_result_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> !result_valid_q)
		else $error("result presented during the reset sweep");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == S_WRITE)
		else $error("result raised outside write-back");

endmodule

>>> bench/tb_route_dedup_hash_table.sv
// Self-checking bench for the route de-duplication table: directed and random add, remove,
// clear and unused-action requests, checked against an in-bench model of the buckets and
// route count. Depends on rdh_pkg and route_dedup_hash_table.
module tb_route_dedup_hash_table;
	import rdh_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int BUCKETS       = TABLE_SIZE_DEF;
	localparam int SLOTS         = BUCKET_ENTRIES_DEF;
	localparam int HOT_BUCKETS   = 3;
	localparam int TAG_POOL      = 12;
	localparam int IDLE_PERCENT  = 29;
	localparam int SETTLE_CYCLES = 8;

	logic             clk;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	item_t            item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;
	logic             cfg_wen      = 1'b0;
	logic [EPS_W-1:0] cfg_wdata    = '0;

	bit idle_en = 1'b1;

	int unsigned       fill_of [BUCKETS] = '{default: 0};
	logic [TAG_W-1:0]  held_tag [BUCKETS*SLOTS];
	logic [RLEN_W-1:0] held_len [BUCKETS*SLOTS];
	int unsigned       routes_held = 0;
	logic [EPS_W-1:0]  epsilon     = EPS_RESET;

	logic [BIDX_W-1:0] hot_buckets [HOT_BUCKETS];
	logic [TAG_W-1:0]  tag_base;

	result_t outcomes_due [$];
	int      mismatches       = 0;
	int      requests_sent    = 0;
	int      epsilon_settings = 1;
	int      status_tally [7] = '{default: 0};

	route_dedup_hash_table u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("route_dedup_hash_table regression: fail");
		$finish;
	end

	function automatic result_t apply_route_request(input item_t req);
		result_t           outcome;
		logic [STATUS_W-1:0] st;
		logic [RLEN_W-1:0] old;
		int unsigned       b, base, n, i;
		int                hit;
		b = req.bucket_index % BUCKETS;
		base = b * SLOTS;
		n = fill_of[b];
		hit = -1;
		for (i = 0; i < n; i++)
			if (hit < 0 && held_tag[base+i] == req.tag)
				hit = i;
		case (req.action)
			ACT_ADD: begin
				if (hit >= 0) begin
					old = held_len[base+hit];
					if (req.route_length < old && (old - req.route_length) > epsilon) begin
						held_len[base+hit] = req.route_length;
						st = ST_BETTER;
					end else begin
						st = ST_DUPLICATE;
					end
				end else if (n >= SLOTS) begin
					st = ST_FULL;
				end else begin
					held_tag[base+n] = req.tag;
					held_len[base+n] = req.route_length;
					fill_of[b] = n + 1;
					routes_held++;
					st = ST_ADDED;
				end
			end
			ACT_REMOVE: begin
				if (hit >= 0) begin
					for (i = hit + 1; i < n; i++) begin
						held_tag[base+i-1] = held_tag[base+i];
						held_len[base+i-1] = held_len[base+i];
					end
					fill_of[b] = n - 1;
					routes_held--;
					st = ST_REMOVED;
				end else begin
					st = ST_NOT_FOUND;
				end
			end
			ACT_CLEAR: begin
				foreach (fill_of[j])
					fill_of[j] = 0;
				routes_held = 0;
				st = ST_CLEARED;
			end
			default: st = ST_NOT_FOUND;
		endcase
		outcome.status = st;
		outcome.route_count = routes_held[COUNT_W-1:0];
		return outcome;
	endfunction

	function automatic item_t make_request(input logic [ACTION_W-1:0] action,
			input logic [BIDX_W-1:0] bucket, input logic [TAG_W-1:0] tag,
			input logic [RLEN_W-1:0] length);
		item_t req;
		req.action = action;
		req.bucket_index = bucket;
		req.tag = tag;
		req.route_length = length;
		return req;
	endfunction

	// Mostly traffic on a few hot buckets with a small tag pool, so buckets fill up and
	// tags collide; lengths are often pulled just around the epsilon margin.
	function automatic item_t random_request();
		item_t             req;
		int unsigned       pick, base, n, i, delta;
		logic              found;
		logic [RLEN_W-1:0] old;
		pick = $urandom_range(99);
		req.action = ACT_ADD;
		req.bucket_index = hot_buckets[$urandom_range(HOT_BUCKETS-1)];
		req.tag = tag_base + TAG_W'($urandom_range(TAG_POOL-1));
		req.route_length = $urandom;
		if (pick < 2) begin
			req.action = ACT_CLEAR;
		end else if (pick < 4) begin
			req.action = ACT_UNUSED;
		end else if (pick < 29) begin
			req.action = ACT_REMOVE;
		end else if (pick < 85) begin
			found = 1'b0;
			old = '0;
			base = req.bucket_index * SLOTS;
			n = fill_of[req.bucket_index];
			for (i = 0; i < n; i++)
				if (held_tag[base+i] == req.tag) begin
					found = 1'b1;
					old = held_len[base+i];
				end
			if (found && $urandom_range(3) != 0) begin
				case ($urandom_range(3))
					0: delta = 32'(epsilon);
					1: delta = 32'(epsilon) + 1;
					default: delta = $urandom_range(2 * 32'(epsilon) + 2);
				endcase
				req.route_length = (old > delta) ? old - delta : '0;
			end
		end else begin
			req.action = $urandom_range(1) ? ACT_ADD : ACT_REMOVE;
			req.bucket_index = BIDX_W'($urandom);
			req.tag = TAG_W'($urandom);
		end
		return req;
	endfunction

	task automatic send_request(input item_t req);
		while (idle_en && $urandom_range(99) < IDLE_PERCENT)
			@(posedge clk);
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall !== 1'b0);
		item_valid <= 1'b0;
		outcomes_due.push_back(apply_route_request(req));
		requests_sent++;
		@(posedge clk);
	endtask

	task automatic drain_outcomes();
		item_valid <= 1'b0;
		do @(posedge clk); while (outcomes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [EPS_W-1:0] value);
		drain_outcomes();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		epsilon = value;
		epsilon_settings++;
	endtask

	task automatic test_directed_basics();
		int k;
		send_request(make_request(ACT_ADD, 10'd0, 10'd0, 32'd0));
		send_request(make_request(ACT_ADD, 10'd0, 10'd0, 32'd0));
		send_request(make_request(ACT_ADD, 10'd1023, 10'd1023, 32'hFFFF_FFFF));
		// improvement equal to epsilon is not enough
		send_request(make_request(ACT_ADD, 10'd1023, 10'd1023, 32'hFFFF_FFFE));
		send_request(make_request(ACT_ADD, 10'd1023, 10'd1023, 32'hFFFF_FFFD));
		send_request(make_request(ACT_REMOVE, 10'd1023, 10'd5, 32'd0));
		send_request(make_request(ACT_REMOVE, 10'd7, 10'd0, 32'd0));
		for (k = 0; k < SLOTS; k++)
			send_request(make_request(ACT_ADD, 10'd5, TAG_W'(10 + k), RLEN_W'((k + 1) << 16)));
		send_request(make_request(ACT_ADD, 10'd5, 10'd100, 32'd0));
		send_request(make_request(ACT_ADD, 10'd5, TAG_W'(10 + SLOTS - 1), 32'd0));
		send_request(make_request(ACT_REMOVE, 10'd5, 10'd12, 32'd0));
		send_request(make_request(ACT_ADD, 10'd5, 10'd100, 32'h0003_8000));
		send_request(make_request(ACT_UNUSED, 10'd5, 10'd10, 32'd0));
		send_request(make_request(ACT_CLEAR, 10'd0, 10'd0, 32'd0));
		send_request(make_request(ACT_ADD, 10'd5, 10'd10, 32'h8000_0000));
	endtask

	task automatic test_epsilon_extremes();
		write_epsilon(16'd0);
		send_request(make_request(ACT_ADD, 10'd9, 10'd3, 32'd100));
		send_request(make_request(ACT_ADD, 10'd9, 10'd3, 32'd99));
		write_epsilon(16'hFFFF);
		send_request(make_request(ACT_ADD, 10'd9, 10'd4, 32'h0002_0000));
		send_request(make_request(ACT_ADD, 10'd9, 10'd4, 32'h0001_0001));
		send_request(make_request(ACT_ADD, 10'd9, 10'd4, 32'h0001_0000));
	endtask

	task automatic test_random_traffic(input logic [EPS_W-1:0] eps, input int count,
			input bit idling, input bit pause_midway);
		int i;
		write_epsilon(eps);
		idle_en <= idling;
		tag_base = TAG_W'($urandom);
		foreach (hot_buckets[k])
			hot_buckets[k] = BIDX_W'($urandom);
		for (i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain_outcomes();
			send_request(random_request());
		end
		drain_outcomes();
		idle_en <= 1'b1;
	endtask

	always @(posedge clk) begin
		result_stall <= idle_en && ($urandom_range(99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin
		result_t due;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			if (outcomes_due.size() == 0) begin
				$error("result status %0d count %0d with no request outstanding",
					result.status, result.route_count);
				mismatches++;
			end else begin
				due = outcomes_due.pop_front();
				if (result.status !== due.status) begin
					$error("status: expected %0d, actual %0d", due.status, result.status);
					mismatches++;
				end
				if (result.route_count !== due.route_count) begin
					$error("route_count: expected %0d, actual %0d",
						due.route_count, result.route_count);
					mismatches++;
				end
				status_tally[due.status]++;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_basics();
		test_epsilon_extremes();
		test_random_traffic(EPS_W'($urandom_range(65534, 2)), 100, 1'b1, 1'b0);
		test_random_traffic(16'd0, 100, 1'b0, 1'b0);
		test_random_traffic(16'hFFFF, 100, 1'b1, 1'b1);
		test_random_traffic(EPS_RESET, 100, 1'b1, 1'b0);
		drain_outcomes();
		$display("covered %0d requests under %0d epsilon settings, %0d mismatches",
			requests_sent, epsilon_settings, mismatches);
		$display("added %0d better %0d duplicate %0d removed %0d cleared %0d full %0d missing %0d",
			status_tally[ST_ADDED], status_tally[ST_BETTER], status_tally[ST_DUPLICATE],
			status_tally[ST_REMOVED], status_tally[ST_CLEARED], status_tally[ST_FULL],
			status_tally[ST_NOT_FOUND]);
		if (mismatches == 0 && outcomes_due.size() == 0) begin
			$display("route_dedup_hash_table regression: pass");
		end else begin
			$display("route_dedup_hash_table regression: fail");
		end
		$finish;
	end

endmodule
